>>> rtl/core/bge_pkg.sv
package bge_pkg;

  localparam int MAX_BEATS       = 64;
  localparam int POSITION_BITS   = 24;
  localparam int EASE_TABLE_BITS = 8;

  localparam int BIDX_W   = $clog2(MAX_BEATS);
  localparam int CNT_W    = 7;
  localparam int LEN_W    = 24;
  localparam int FRAME_W  = 24;
  localparam int FRAC_W   = 16;
  localparam int BEAT_Q_W = POSITION_BITS + 8;
  localparam int QW       = BEAT_Q_W + FRAC_W;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;

  localparam logic [GAIN_W-1:0] Q_ONE   = GAIN_W'(32768);
  localparam logic [31:0]       Q_ROUND = 32'd16384;

  localparam int LUT_N  = (1 << (EASE_TABLE_BITS - 1)) + 1;
  localparam int LUT_IW = $clog2(LUT_N);
  localparam int K_W    = EASE_TABLE_BITS - 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_FRAMES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_FRAMES = 2'd3;

  localparam logic [CNT_W-1:0]   RST_BEAT_COUNT   = 7'd64;
  localparam logic [LEN_W-1:0]   RST_BEAT_LENGTH  = 24'd1491985;
  localparam logic [FRAME_W-1:0] RST_LOOP_FRAMES  = 24'd1048576;
  localparam logic [FRAME_W-1:0] RST_AUDIO_FRAMES = 24'd1048576;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_GAIN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RDA,
    ST_RDB,
    ST_MULA,
    ST_MULB,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              mute;
    logic [GAIN_W-1:0] gain;
  } lane_ctrl_t;

  typedef logic [LUT_N-1:0][GAIN_W-1:0] sine_lut_t;

  // quarter sine over phases 2^(E-1) .. 2^E
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    for (int i = 0; i < LUT_N; i++) begin
      x  = longint'((1 << (EASE_TABLE_BITS - 1)) + i) << (15 - EASE_TABLE_BITS);
      x2 = (x * x) >> 15;
      t  = 64'd42048 - ((64'd4640 * x2) >> 15);
      t  = 64'd102944 - ((x2 * t) >> 15);
      s  = (x * t) >> 16;
      if (s > 64'd32768) s = 64'd32768;
      lut[i] = GAIN_W'(s);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

>>> rtl/core/bge_ram.sv
module bge_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/bge_divider.sv
module bge_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bge_pkg::QW-1:0]        dividend,
  input  logic [bge_pkg::LEN_W-1:0]     divisor,
  output logic                          done,
  output logic [bge_pkg::QW-1:0]        quotient
);

  localparam int CW = $clog2(bge_pkg::QW + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [bge_pkg::QW-1:0]      quo_r;
  logic [bge_pkg::LEN_W-1:0]   rem_r;
  logic [bge_pkg::LEN_W-1:0]   div_r;
  logic [bge_pkg::LEN_W:0]     trial;
  logic                        fits;

  assign trial = {rem_r, quo_r[bge_pkg::QW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(bge_pkg::QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[bge_pkg::QW-2:0], fits};
      rem_r <= fits ? bge_pkg::LEN_W'(trial - {1'b0, div_r})
                    : trial[bge_pkg::LEN_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/bge_lane.sv
module bge_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bge_pkg::lane_ctrl_t               ctrl,
  input  logic signed [bge_pkg::SAMPLE_W-1:0] sample,
  output logic signed [bge_pkg::SAMPLE_W-1:0] result
);

  logic signed [33:0] prod_r;
  logic               mute_r;
  logic signed [16:0] gain_s;

  assign gain_s = signed'({1'b0, ctrl.gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r <= 1'b1;
    end else if (ctrl.load) begin
      mute_r <= ctrl.mute;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r <= (34'(sample) * 34'(gain_s)) + 34'sd16384;
    end
  end

  // floor of the rounded product over 2^15
  assign result = mute_r ? '0 : prod_r[30:15];

endmodule

>>> rtl/core/beat_gain_envelope.sv
// Channel  Direction  Transaction
// in_      slave      tuser = request kind; tdata = samples, or beat and gain to store
// out_     master     tdata = scaled samples and loop position, one per frame request
// cfg_     write      register index and data, one write per enabled cycle
//
// A frame goes from accept through the serial divider (48 quotient bits, then done) splitting
// the position into beat and fraction, then two gain table reads, two gain multiplies, the lane
// multiply and the output load, and no request is taken meanwhile. A gain write is taken in idle.
// Reset is synchronous, active low; the gain table reads as zero until written.
// A finished result waits in the output register while the next request is taken.
module beat_gain_envelope (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // left_sample, right_sample, beat_number, beat_gain
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // left_out, right_out, frame_position
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int PW = bge_pkg::POSITION_BITS;

  bge_pkg::state_t state_r, state_nxt;

  logic [bge_pkg::CNT_W-1:0]   beat_count_r;
  logic [bge_pkg::LEN_W-1:0]   beat_length_r;
  logic [bge_pkg::FRAME_W-1:0] loop_frames_r;
  logic [bge_pkg::FRAME_W-1:0] audio_frames_r;
  logic [PW-1:0]               position_r;
  logic [bge_pkg::MAX_BEATS-1:0] gvalid_r;

  logic signed [15:0] left_r, right_r;
  logic [bge_pkg::BIDX_W-1:0] a_addr_r, b_addr_r;
  logic [bge_pkg::GAIN_W-1:0] w_r, a_r, b_r, gain_r;
  logic [31:0]                prod_a_r;
  logic                       rd_vld_r;

  logic        out_valid_r;
  logic [55:0] out_data_r;

  logic in_acc, is_gain, do_write, div_start, div_done, out_free;
  logic [bge_pkg::QW-1:0]       quotient;
  logic [bge_pkg::LEN_W-1:0]    len_eff;
  logic [bge_pkg::CNT_W-1:0]    count_eff;
  logic [bge_pkg::BIDX_W-1:0]   last_idx, beat_idx, prev_idx, next_idx;
  logic [bge_pkg::BIDX_W-1:0]   wr_addr, rd_addr;
  logic [bge_pkg::GAIN_W-1:0]   wr_gain, rd_data, gain_in;
  logic [bge_pkg::BEAT_Q_W-1:0] q_beat;
  logic [bge_pkg::FRAC_W-1:0]   frac;
  logic [bge_pkg::K_W-1:0]      k;
  logic [bge_pkg::LUT_IW-1:0]   lut_idx;
  logic [bge_pkg::GAIN_W-1:0]   s_val;
  logic [31:0]                  g_sum;
  logic [PW-1:0]                pos_inc, position_nxt;
  logic signed [15:0]           left_res, right_res;
  bge_pkg::lane_ctrl_t          lane_ctrl;

  assign in_acc   = in_tvalid && in_tready;
  assign is_gain  = in_tuser == bge_pkg::REQ_GAIN;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bge_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      bge_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && !is_gain) begin
          div_start = 1'b1;
          state_nxt = bge_pkg::ST_DIV;
        end
      end
      bge_pkg::ST_DIV: begin
        if (div_done) state_nxt = bge_pkg::ST_RDA;
      end
      bge_pkg::ST_RDA:   state_nxt = bge_pkg::ST_RDB;
      bge_pkg::ST_RDB:   state_nxt = bge_pkg::ST_MULA;
      bge_pkg::ST_MULA:  state_nxt = bge_pkg::ST_MULB;
      bge_pkg::ST_MULB:  state_nxt = bge_pkg::ST_SCALE;
      bge_pkg::ST_SCALE: state_nxt = bge_pkg::ST_OUT;
      bge_pkg::ST_OUT: begin
        if (out_free) state_nxt = bge_pkg::ST_IDLE;
      end
      default: state_nxt = bge_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_count_r   <= bge_pkg::RST_BEAT_COUNT;
      beat_length_r  <= bge_pkg::RST_BEAT_LENGTH;
      loop_frames_r  <= bge_pkg::RST_LOOP_FRAMES;
      audio_frames_r <= bge_pkg::RST_AUDIO_FRAMES;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bge_pkg::CFG_BEAT_COUNT:   beat_count_r   <= cfg_wdata[bge_pkg::CNT_W-1:0];
        bge_pkg::CFG_BEAT_LENGTH:  beat_length_r  <= cfg_wdata;
        bge_pkg::CFG_LOOP_FRAMES:  loop_frames_r  <= cfg_wdata;
        bge_pkg::CFG_AUDIO_FRAMES: audio_frames_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // gain table
  assign do_write = in_acc && is_gain && (32'(in_tdata[37:32]) < bge_pkg::MAX_BEATS);
  assign wr_addr  = bge_pkg::BIDX_W'(in_tdata[37:32]);
  assign gain_in  = in_tdata[53:38];
  assign wr_gain  = (gain_in > bge_pkg::Q_ONE) ? bge_pkg::Q_ONE : gain_in;
  assign rd_addr  = (state_r == bge_pkg::ST_RDB) ? b_addr_r : a_addr_r;

  bge_ram #(
    .WIDTH(bge_pkg::GAIN_W),
    .DEPTH(bge_pkg::MAX_BEATS)
  ) u_gain_ram (
    .clk    (clk),
    .wr_en  (do_write),
    .wr_addr(wr_addr),
    .wr_data(wr_gain),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvalid_r <= '0;
    end else if (do_write) begin
      gvalid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= gvalid_r[rd_addr];
  end

  // beat and fraction
  assign len_eff = (beat_length_r == '0) ? bge_pkg::LEN_W'(1) : beat_length_r;

  bge_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend({position_r, 8'd0, 16'd0}),
    .divisor (len_eff),
    .done    (div_done),
    .quotient(quotient)
  );

  always_comb begin
    if (beat_count_r == '0) begin
      count_eff = bge_pkg::CNT_W'(1);
    end else if (32'(beat_count_r) > bge_pkg::MAX_BEATS) begin
      count_eff = bge_pkg::CNT_W'(bge_pkg::MAX_BEATS);
    end else begin
      count_eff = beat_count_r;
    end
  end

  assign q_beat   = quotient[bge_pkg::QW-1:bge_pkg::FRAC_W];
  assign frac     = quotient[bge_pkg::FRAC_W-1:0];
  assign last_idx = bge_pkg::BIDX_W'(count_eff - 1'b1);
  assign beat_idx = (q_beat >= bge_pkg::BEAT_Q_W'(count_eff)) ? last_idx
                                                              : bge_pkg::BIDX_W'(q_beat);
  assign prev_idx = (beat_idx == '0) ? last_idx : beat_idx - 1'b1;
  assign next_idx = (beat_idx == last_idx) ? '0 : beat_idx + 1'b1;

  assign k       = frac[14:bge_pkg::FRAC_W-bge_pkg::EASE_TABLE_BITS];
  assign lut_idx = frac[15] ? bge_pkg::LUT_IW'(bge_pkg::LUT_N - 1) - bge_pkg::LUT_IW'(k)
                            : bge_pkg::LUT_IW'(k);
  assign s_val   = bge_pkg::SINE_LUT[lut_idx];

  assign g_sum = prod_a_r + (32'(b_r) * 32'(w_r)) + bge_pkg::Q_ROUND;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= signed'(in_tdata[15:0]);
      right_r <= signed'(in_tdata[31:16]);
    end
    if (state_r == bge_pkg::ST_DIV && div_done) begin
      a_addr_r <= frac[15] ? beat_idx : prev_idx;
      b_addr_r <= frac[15] ? next_idx : beat_idx;
      w_r      <= frac[15] ? bge_pkg::Q_ONE - s_val : s_val;
    end
    if (state_r == bge_pkg::ST_RDB) begin
      a_r <= rd_vld_r ? rd_data : '0;
    end
    if (state_r == bge_pkg::ST_MULA) begin
      b_r      <= rd_vld_r ? rd_data : '0;
      prod_a_r <= 32'(a_r) * 32'(bge_pkg::Q_ONE - w_r);
    end
    if (state_r == bge_pkg::ST_MULB) begin
      gain_r <= g_sum[30:15];
    end
  end

  // lanes
  assign lane_ctrl.load = state_r == bge_pkg::ST_SCALE;
  assign lane_ctrl.mute = 32'(position_r) >= 32'(audio_frames_r);
  assign lane_ctrl.gain = gain_r;

  bge_lane u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .sample(left_r),
    .result(left_res)
  );

  bge_lane u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .sample(right_r),
    .result(right_res)
  );

  // merge and position advance
  assign pos_inc      = position_r + 1'b1;
  assign position_nxt = (32'(pos_inc) >= 32'(loop_frames_r)) ? '0 : pos_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      position_r  <= '0;
    end else begin
      if (out_tready) out_valid_r <= 1'b0;
      if (state_r == bge_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        position_r  <= position_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bge_pkg::ST_OUT && out_free) begin
      out_data_r <= {bge_pkg::FRAME_W'(position_r), right_res, left_res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_gain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bge_pkg::ST_SCALE |-> gain_r <= bge_pkg::Q_ONE)
    else $error("envelope gain above one");

  a_addr_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bge_pkg::ST_RDA |->
      (32'(a_addr_r) < 32'(count_eff)) && (32'(b_addr_r) < 32'(count_eff)))
    else $error("gain table address beyond beat count");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == bge_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bge_pkg::ST_OUT && out_valid_r && !out_tready) |=>
      (state_r == bge_pkg::ST_OUT && $stable(position_r)))
    else $error("result overwritten while output stalled");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 64;

  typedef struct packed {
    logic [23:0] pos;
    logic [15:0] right;
    logic [15:0] left;
  } scaled_t;

  typedef enum logic [1:0] {ROW_FRAME, ROW_GAIN, ROW_REG} row_kind_t;

  // arg_a: left sample, beat number or register index
  // arg_b: right sample, gain or register value
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] arg_a;
    logic [23:0] arg_b;
    logic        known;
    scaled_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // left_sample, right_sample, beat_number, beat_gain, pad
  logic        in_tuser = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // left_out, right_out, frame_position
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  // expectation typed into the table, travels with the transaction
  logic    typed_known = 1'b0;
  scaled_t typed_want = '0;

  // predictor state
  logic [6:0]  beats_in_loop;
  logic [23:0] frames_per_beat;
  logic [23:0] loop_len;
  logic [23:0] audio_len;
  logic [23:0] loop_pos;
  logic [15:0] gain_store [bge_pkg::MAX_BEATS];

  scaled_t   pending_frames[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        out_hold = 0;
  bit        in_quiet = 1'b0;
  bit        out_quiet = 1'b0;

  beat_gain_envelope u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned ease_sine(longint unsigned phase);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = phase << (15 - bge_pkg::EASE_TABLE_BITS);
    x2 = (x * x) >> 15;
    t  = 64'd42048 - ((64'd4640 * x2) >> 15);
    t  = 64'd102944 - ((x2 * t) >> 15);
    s  = (x * t) >> 16;
    return (s > 64'd32768) ? 64'd32768 : s;
  endfunction

  function automatic logic [15:0] scale_lane(logic [15:0] smp, longint unsigned g);
    longint p;
    p = longint'($signed(smp)) * longint'(g) + 64'sd16384;
    return 16'(p >>> 15);
  endfunction

  function automatic void store_gain(logic [5:0] beat, logic [15:0] g);
    if (beat < bge_pkg::MAX_BEATS)
      gain_store[beat] = (g > 16'd32768) ? 16'd32768 : g;
  endfunction

  function automatic scaled_t envelope_step(logic [15:0] left, logic [15:0] right);
    longint unsigned cnt, len, n, beat, frac, prv, nxt, a, b, w, g, k;
    scaled_t res;
    cnt = (beats_in_loop == 0) ? 1 : beats_in_loop;
    if (cnt > bge_pkg::MAX_BEATS) cnt = bge_pkg::MAX_BEATS;
    len = (frames_per_beat == 0) ? 1 : frames_per_beat;
    n    = longint'(loop_pos) << 8;
    beat = n / len;
    frac = ((n % len) << 16) / len;
    if (beat >= cnt) beat = cnt - 1;
    prv = (beat == 0) ? cnt - 1 : beat - 1;
    nxt = (beat + 1 == cnt) ? 0 : beat + 1;
    if (frac < 32768) begin
      k = frac >> (16 - bge_pkg::EASE_TABLE_BITS);
      w = ease_sine((64'd1 << (bge_pkg::EASE_TABLE_BITS - 1)) + k);
      a = gain_store[prv];
      b = gain_store[beat];
    end else begin
      k = (frac - 32768) >> (16 - bge_pkg::EASE_TABLE_BITS);
      w = 64'd32768 - ease_sine((64'd1 << bge_pkg::EASE_TABLE_BITS) - k);
      a = gain_store[beat];
      b = gain_store[nxt];
    end
    g = (a * (64'd32768 - w) + b * w + 64'd16384) >> 15;
    if (loop_pos >= audio_len) begin
      res.left  = '0;
      res.right = '0;
    end else begin
      res.left  = scale_lane(left, g);
      res.right = scale_lane(right, g);
    end
    res.pos = loop_pos;
    loop_pos = loop_pos + 24'd1;
    if (loop_pos >= loop_len) loop_pos = '0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    mismatches++;
    $display("mismatch %s: got 0x%0h expected 0x%0h (cycle %0d)", what, got, want, cycles);
  endtask

  function automatic void tab_frame(logic [15:0] l, logic [15:0] r, logic known, scaled_t want);
    stim_row_t row;
    row.kind  = ROW_FRAME;
    row.arg_a = l;
    row.arg_b = {8'd0, r};
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void tab_write(row_kind_t kind, logic [15:0] sel, logic [23:0] value);
    stim_row_t row;
    row.kind  = kind;
    row.arg_a = sel;
    row.arg_b = value;
    row.known = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_req(input logic kind, input logic [55:0] data, input logic known,
                          input scaled_t want);
    int gap;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser    <= kind;
    in_tdata    <= data;
    typed_known <= known;
    typed_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      bge_pkg::CFG_BEAT_COUNT:   beats_in_loop   = value[6:0];
      bge_pkg::CFG_BEAT_LENGTH:  frames_per_beat = value;
      bge_pkg::CFG_LOOP_FRAMES:  loop_len        = value;
      bge_pkg::CFG_AUDIO_FRAMES: audio_len       = value;
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] l, input logic [15:0] r, input logic known,
                            input scaled_t want);
    send_req(bge_pkg::REQ_FRAME, {24'd0, r, l}, known, want);
  endtask

  task automatic send_gain(input logic [5:0] beat, input logic [15:0] g);
    send_req(bge_pkg::REQ_GAIN, {2'b00, g, beat, 32'd0}, 1'b0, '0);
  endtask

  // prediction on input transactions, checking on output transactions
  always @(posedge clk) begin : scoreboard
    scaled_t want;
    scaled_t predicted;
    int hold;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == bge_pkg::REQ_GAIN) begin
          store_gain(in_tdata[37:32], in_tdata[53:38]);
        end else begin
          predicted = envelope_step(in_tdata[15:0], in_tdata[31:16]);
          pending_frames.push_back(typed_known ? typed_want : predicted);
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_frames.size() == 0) begin
          report_mismatch("result with nothing expected", out_tdata[55:32], '0);
        end else begin
          want = pending_frames.pop_front();
          if (out_tdata[15:0] !== want.left)
            report_mismatch("left_out", {8'd0, out_tdata[15:0]}, {8'd0, want.left});
          if (out_tdata[31:16] !== want.right)
            report_mismatch("right_out", {8'd0, out_tdata[31:16]}, {8'd0, want.right});
          if (out_tdata[55:32] !== want.pos)
            report_mismatch("frame_position", out_tdata[55:32], want.pos);
        end
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        hold = out_quiet ? 0 : $urandom_range(0, 16);
        out_hold   <= hold;
        out_tready <= (hold == 0);
      end else if (out_hold > 0) begin
        out_hold   <= out_hold - 1;
        out_tready <= (out_hold == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    logic [23:0] value;
    beats_in_loop   = bge_pkg::RST_BEAT_COUNT;
    frames_per_beat = bge_pkg::RST_BEAT_LENGTH;
    loop_len        = bge_pkg::RST_LOOP_FRAMES;
    audio_len       = bge_pkg::RST_AUDIO_FRAMES;
    loop_pos        = '0;
    for (int i = 0; i < bge_pkg::MAX_BEATS; i++) gain_store[i] = '0;

    // empty gain table gives silence
    tab_frame(16'h7FFF, 16'h8000, 1'b1, {24'd0, 16'h0000, 16'h0000});
    tab_write(ROW_GAIN, 16'd0, 24'd32768);
    tab_write(ROW_GAIN, 16'd63, 24'd65535);
    tab_write(ROW_GAIN, 16'd1, 24'd32769);
    // unity on both sides of beat 0 passes the samples through
    tab_frame(16'h7FFF, 16'h8000, 1'b1, {24'd1, 16'h8000, 16'h7FFF});
    tab_frame(16'h0000, 16'hFFFF, 1'b1, {24'd2, 16'hFFFF, 16'h0000});
    tab_write(ROW_GAIN, 16'd2, 24'd16384);
    tab_write(ROW_REG, 16'(bge_pkg::CFG_AUDIO_FRAMES), 24'd0);
    tab_frame(16'h1234, 16'h5678, 1'b1, {24'd3, 16'h0000, 16'h0000});
    tab_write(ROW_REG, 16'(bge_pkg::CFG_AUDIO_FRAMES), 24'hFFFFFF);
    // zero beat length, beat index clamped
    tab_write(ROW_REG, 16'(bge_pkg::CFG_BEAT_LENGTH), 24'd0);
    tab_frame(16'h4000, 16'hC000, 1'b0, '0);
    tab_write(ROW_REG, 16'(bge_pkg::CFG_BEAT_COUNT), 24'd0);
    tab_frame(16'h7FFF, 16'h8001, 1'b0, '0);
    tab_write(ROW_REG, 16'(bge_pkg::CFG_BEAT_COUNT), 24'd127);
    // one and a half frames per beat: both halves of a beat
    tab_write(ROW_REG, 16'(bge_pkg::CFG_BEAT_LENGTH), 24'd384);
    tab_frame(16'h2000, 16'hE000, 1'b0, '0);
    tab_frame(16'h7FFF, 16'h8000, 1'b0, '0);
    tab_frame(16'h0001, 16'hFFFF, 1'b0, '0);
    tab_write(ROW_REG, 16'(bge_pkg::CFG_LOOP_FRAMES), 24'd0);
    tab_frame(16'h3333, 16'hCCCC, 1'b0, '0);
    tab_frame(16'h7FFF, 16'h8000, 1'b1, {24'd0, 16'h8000, 16'h7FFF});
    tab_write(ROW_REG, 16'(bge_pkg::CFG_LOOP_FRAMES), 24'd3);
    tab_frame(16'h1111, 16'h2222, 1'b0, '0);
    tab_frame(16'h3333, 16'h4444, 1'b0, '0);
    tab_frame(16'h5555, 16'h6666, 1'b0, '0);
    tab_write(ROW_REG, 16'(bge_pkg::CFG_BEAT_LENGTH), 24'hFFFFFF);
    tab_write(ROW_REG, 16'(bge_pkg::CFG_LOOP_FRAMES), 24'hFFFFFF);
    tab_frame(16'hABCD, 16'h5432, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    while (directed_rows.size() != 0) begin
      row = directed_rows.pop_front();
      case (row.kind)
        ROW_FRAME: send_frame(row.arg_a, row.arg_b[15:0], row.known, row.want);
        ROW_GAIN:  send_gain(row.arg_a[5:0], row.arg_b[15:0]);
        ROW_REG:   write_reg(row.arg_a[1:0], row.arg_b);
        default: ;
      endcase
    end

    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 5))
        0: value = 24'd0;
        1: value = 24'd1;
        2: value = 24'd64;
        3: value = 24'($urandom_range(65, 127));
        default: value = 24'($urandom_range(2, 63));
      endcase
      write_reg(bge_pkg::CFG_BEAT_COUNT, value);
      case ($urandom_range(0, 5))
        0: value = 24'd0;
        1: value = 24'd256;
        2: value = 24'hFFFFFF;
        3: value = 24'($urandom);
        default: value = 24'($urandom_range(256, 6000));
      endcase
      write_reg(bge_pkg::CFG_BEAT_LENGTH, value);
      case ($urandom_range(0, 5))
        0: value = 24'd0;
        1: value = 24'd1;
        2: value = 24'hFFFFFF;
        3: value = 24'($urandom);
        default: value = 24'($urandom_range(2, 300));
      endcase
      write_reg(bge_pkg::CFG_LOOP_FRAMES, value);
      case ($urandom_range(0, 4))
        0: value = 24'd0;
        1: value = 24'hFFFFFF;
        2: value = 24'($urandom);
        default: value = 24'($urandom_range(0, 300));
      endcase
      write_reg(bge_pkg::CFG_AUDIO_FRAMES, value);

      for (int i = 0; i < 105; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 7))
            0: value = 24'd0;
            1: value = 24'd32768;
            2: value = 24'($urandom_range(32769, 65535));
            default: value = 24'($urandom_range(0, 32768));
          endcase
          send_gain(6'($urandom), value[15:0]);
        end else begin
          send_frame(draw_sample(), draw_sample(), 1'b0, '0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bge_pkg.sv
rtl/core/bge_ram.sv
rtl/core/bge_divider.sv
rtl/core/bge_lane.sv
rtl/core/beat_gain_envelope.sv
tb/tb.sv
